// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file ols_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds whenever reset is released
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the next clock
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ols_pkg.sv -----
package ols_pkg;
    localparam int unsigned Capacity = 256;
    localparam int unsigned SlotW = $clog2(Capacity);
    localparam int unsigned CountW = $clog2(Capacity + 1);

    localparam logic [3:0] CMD_INS_START  = 4'd0;
    localparam logic [3:0] CMD_INS_END    = 4'd1;
    localparam logic [3:0] CMD_INS_AFTER  = 4'd2;
    localparam logic [3:0] CMD_INS_BEFORE = 4'd3;
    localparam logic [3:0] CMD_GET_FIRST  = 4'd4;
    localparam logic [3:0] CMD_GET_LAST   = 4'd5;
    localparam logic [3:0] CMD_POP_FIRST  = 4'd6;
    localparam logic [3:0] CMD_POP_LAST   = 4'd7;
    localparam logic [3:0] CMD_REMOVE     = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOKEY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEEK,
        S_WALK,
        S_FREEHD,
        S_RDPREV,
        S_LINK,
        S_POPHEAD,
        S_RDVAL,
        S_DONE
    } state_t;
endpackage

// ----- sv/ordered_list_store.sv -----
// States from request to result: S_DISPATCH, S_DONE for unknown, refused and empty-list cases;
// get, pop_first: S_RDVAL, S_POPHEAD, S_LINK; insert at start or end: S_FREEHD, S_RDPREV, S_LINK.
// Key searches and pop_last walk the chain at one slot-memory read per cycle:
// at most one read per list entry; the block passes through S_IDLE before it takes the next request.
// One request at a time; a result waits in the output register while the next is taken.
// Reset (rst_n, async, active low) empties the list; slot memories are not cleared.
module ordered_list_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // command[3:0], key[35:4], value[67:36], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // status[1:0], data[33:2], length[42:34], zero pad
);
    import ols_pkg::*;

    logic [31:0]      val_mem [Capacity];
    logic [SlotW-1:0] lnk_mem [Capacity];

    state_t state_reg, state_next;
    logic [3:0]        cmd_reg;
    logic [31:0]       key_reg, value_reg;
    logic [SlotW-1:0]  first_reg, last_reg, freeh_reg;
    logic [CountW-1:0] freec_reg, unused_reg, count_reg;
    logic [SlotW-1:0]  cur_reg, prv_reg, nslot_reg;
    logic [CountW-1:0] pos_reg;
    logic [1:0]        st_reg;
    logic [31:0]       data_reg;
    logic              out_v_reg;
    logic [42:0]       res_reg;
    logic              out_load;

    // memory port control
    logic [SlotW-1:0] rd_addr;
    logic [31:0]      rd_val;
    logic [SlotW-1:0] rd_lnk;
    logic             vw_en, lw_en;
    logic [SlotW-1:0] vw_addr, lw_addr;
    logic [SlotW-1:0] lw_data;

    always_ff @(posedge clk)
    begin
        rd_val <= val_mem[rd_addr];
        rd_lnk <= lnk_mem[rd_addr];
        if (vw_en)
        begin
            val_mem[vw_addr] <= value_reg;
        end
        if (lw_en)
        begin
            lnk_mem[lw_addr] <= lw_data;
        end
    end

    logic is_ins, full, empty_cmd;
    assign is_ins    = cmd_reg <= CMD_INS_BEFORE;
    assign full      = is_ins && (count_reg >= CountW'(Capacity));
    assign empty_cmd = (cmd_reg >= CMD_GET_FIRST) && (cmd_reg <= CMD_REMOVE)
                       && (count_reg == '0);

    logic [SlotW-1:0] new_slot;
    assign new_slot = (freec_reg != '0) ? freeh_reg : unused_reg[SlotW-1:0];

    logic hit, seek_end;
    assign hit      = rd_val == key_reg;
    assign seek_end = pos_reg + CountW'(1) == count_reg;

    // second link write for a splice at any position after the head, done in S_DONE
    logic splice;
    assign splice = (state_reg == S_DONE) && (st_reg == ST_OK) && pos_reg != '0 &&
                    (is_ins || cmd_reg == CMD_REMOVE || cmd_reg == CMD_POP_LAST);

    logic [SlotW-1:0] splice_next_reg;

    assign out_load = (state_reg == S_DONE) && (!out_v_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'd0, res_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (full || empty_cmd)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_INS_START, CMD_INS_END: state_next = S_FREEHD;
                        CMD_INS_AFTER, CMD_INS_BEFORE, CMD_REMOVE:
                            state_next = (count_reg == '0) ? S_DONE : S_SEEK;
                        CMD_GET_FIRST, CMD_GET_LAST, CMD_POP_FIRST: state_next = S_RDVAL;
                        CMD_POP_LAST: state_next = (count_reg == CountW'(1)) ?
                                                   S_RDVAL : S_WALK;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_SEEK:
            begin
                if (hit)
                begin
                    state_next = (cmd_reg == CMD_REMOVE) ? S_RDPREV : S_FREEHD;
                end
                else if (seek_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                if (pos_reg + CountW'(2) >= count_reg)
                begin
                    state_next = S_RDVAL;
                end
            end
            S_FREEHD:  state_next = S_RDPREV;
            S_RDPREV:  state_next = S_LINK;
            S_RDVAL:   state_next = S_POPHEAD;
            S_POPHEAD: state_next = S_LINK;
            S_LINK:    state_next = S_DONE;
            // hold until the output register is free
            S_DONE:    state_next = out_load ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    // memory addressing
    always_comb
    begin
        rd_addr = cur_reg;
        vw_en   = 1'b0;
        lw_en   = 1'b0;
        vw_addr = nslot_reg;
        lw_addr = nslot_reg;
        lw_data = cur_reg;
        case (state_reg)
            S_DISPATCH:
            begin
                rd_addr = (cmd_reg == CMD_GET_LAST) ? last_reg : first_reg;
            end
            S_SEEK, S_WALK:
            begin
                rd_addr = rd_lnk;
            end
            S_FREEHD:
            begin
                rd_addr = new_slot;
            end
            S_RDPREV:
            begin
                rd_addr = (cmd_reg == CMD_REMOVE) ? cur_reg : prv_reg;
            end
            S_RDVAL:
            begin
                rd_addr = (cmd_reg == CMD_POP_LAST && count_reg != CountW'(1)) ?
                          last_reg : cur_reg;
            end
            S_LINK:
            begin
                if (is_ins)
                begin
                    vw_en = 1'b1;
                    lw_en = 1'b1;
                    lw_addr = nslot_reg;
                    lw_data = (pos_reg == '0) ? first_reg : rd_lnk;
                end
                else if (cmd_reg == CMD_POP_FIRST || cmd_reg == CMD_POP_LAST
                         || cmd_reg == CMD_REMOVE)
                begin
                    // release slot cur_reg to free chain
                    lw_en = 1'b1;
                    lw_addr = cur_reg;
                    lw_data = freeh_reg;
                end
            end
            S_DONE:
            begin
                if (splice)
                begin
                    lw_en = 1'b1;
                    lw_addr = prv_reg;
                    lw_data = is_ins ? nslot_reg : splice_next_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            first_reg  <= '0;
            last_reg   <= '0;
            freeh_reg  <= '0;
            freec_reg  <= '0;
            unused_reg <= '0;
            count_reg  <= '0;
            out_v_reg  <= 1'b0;
            res_reg    <= '0;
            st_reg     <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_v_reg <= 1'b1;
                res_reg   <= {count_reg, data_reg, st_reg};
            end
            else if (m_tvalid && m_tready)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        cmd_reg   <= s_tdata[3:0];
                        key_reg   <= s_tdata[35:4];
                        value_reg <= s_tdata[67:36];
                        st_reg    <= ST_OK;
                        data_reg  <= '0;
                    end
                end
                S_DISPATCH:
                begin
                    pos_reg <= '0;
                    cur_reg <= first_reg;
                    prv_reg <= first_reg;
                    if (full)
                    begin
                        st_reg <= ST_FULL;
                    end
                    else if (empty_cmd)
                    begin
                        st_reg <= ST_EMPTY;
                    end
                    else if ((cmd_reg == CMD_INS_AFTER || cmd_reg == CMD_INS_BEFORE)
                             && count_reg == '0)
                    begin
                        st_reg <= ST_NOKEY;
                    end
                    else if (cmd_reg == CMD_INS_END)
                    begin
                        pos_reg <= count_reg;
                        prv_reg <= last_reg;
                    end
                    else if (cmd_reg == CMD_GET_LAST)
                    begin
                        cur_reg <= last_reg;
                    end
                end
                S_SEEK:
                begin
                    // rd_val/rd_lnk belong to cur_reg
                    if (hit)
                    begin
                        if (cmd_reg == CMD_INS_AFTER)
                        begin
                            prv_reg <= cur_reg;
                            pos_reg <= pos_reg + CountW'(1);
                        end
                    end
                    else if (seek_end)
                    begin
                        st_reg  <= ST_NOKEY;
                        pos_reg <= count_reg;
                    end
                    else
                    begin
                        prv_reg <= cur_reg;
                        cur_reg <= rd_lnk;
                        pos_reg <= pos_reg + CountW'(1);
                    end
                end
                S_WALK:
                begin
                    if (pos_reg + CountW'(2) < count_reg)
                    begin
                        cur_reg <= rd_lnk;
                        pos_reg <= pos_reg + CountW'(1);
                    end
                    else
                    begin
                        prv_reg <= cur_reg;
                        cur_reg <= last_reg;
                        pos_reg <= count_reg - CountW'(1);
                    end
                end
                S_FREEHD:
                begin
                    nslot_reg <= new_slot;
                end
                S_RDPREV:
                begin
                    if (is_ins && freec_reg != '0)
                    begin
                        freeh_reg <= rd_lnk;
                        freec_reg <= freec_reg - CountW'(1);
                    end
                    else if (is_ins)
                    begin
                        unused_reg <= unused_reg + CountW'(1);
                    end
                end
                S_RDVAL:
                begin
                    if (cmd_reg != CMD_GET_FIRST && cmd_reg != CMD_GET_LAST)
                    begin
                        data_reg <= '0;
                    end
                end
                S_POPHEAD:
                begin
                    if (cmd_reg == CMD_GET_FIRST || cmd_reg == CMD_GET_LAST
                        || cmd_reg == CMD_POP_FIRST || cmd_reg == CMD_POP_LAST)
                    begin
                        data_reg <= rd_val;
                    end
                end
                S_LINK:
                begin
                    if (is_ins)
                    begin
                        if (pos_reg == '0)
                        begin
                            first_reg <= nslot_reg;
                        end
                        if (pos_reg == count_reg)
                        begin
                            last_reg <= nslot_reg;
                        end
                        count_reg <= count_reg + CountW'(1);
                    end
                    else if (cmd_reg == CMD_POP_FIRST || cmd_reg == CMD_POP_LAST
                             || cmd_reg == CMD_REMOVE)
                    begin
                        splice_next_reg <= rd_lnk;
                        if (pos_reg == '0)
                        begin
                            first_reg <= rd_lnk;
                        end
                        if (pos_reg + CountW'(1) == count_reg && pos_reg != '0)
                        begin
                            last_reg <= prv_reg;
                        end
                        count_reg <= count_reg - CountW'(1);
                        freeh_reg <= cur_reg;
                        freec_reg <= freec_reg + CountW'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- sv/ols_checker.sv -----
`include "assert_macros.svh"
module ols_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    `CHK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `CHK_ASSERT(a_len, m_tvalid |-> m_tdata[42:34] <= 9'd256, "length over capacity")
    `CHK_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "second request taken while busy")
    `CHK_ASSERT(a_full_len, m_tvalid && m_tdata[1:0] == 2'd3 |-> m_tdata[42:34] == 9'd256,
        "full status below capacity")
endmodule

bind ordered_list_store ols_checker u_ols_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
